FILE: sv/ctt_pkg.sv
package ctt_pkg;

  localparam int DEF_ENTRIES = 64;
  localparam int SLOT_W      = 6;

  typedef enum logic [1:0] {
    KIND_GET   = 2'd0,
    KIND_OPEN  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_DROP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_EXISTS     = 3'd2,
    ST_FULL       = 3'd3,
    ST_DROPPED    = 3'd4,
    ST_BAD_HANDLE = 3'd5
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [31:0]        src_ip;
    logic [31:0]        dst_ip;
    logic [15:0]        src_port;
    logic [15:0]        dst_port;
    logic [SLOT_W-1:0]  handle;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic               forward;
    logic               dropped_flag;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic        dropped;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] ports;
  } entry_t;

  typedef struct packed {
    logic fwd_hit;
    logic fwd_drop;
    logic rev_hit;
    logic rev_drop;
    logic free_hit;
  } match_flags_t;

endpackage

FILE: sv/ctt_stream_if.sv
interface ctt_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/tcp_connection_table_top.sv
// Connection table of ENTRIES slots keyed by the IPv4/TCP 4-tuple, matched as given or
// reversed. Get and open scan the table one slot per cycle through its single read port,
// comparing each slot against the forward and reversed tuple, then pass through S_DRAIN
// and S_DECIDE to S_RESP; an open that replaces a dropped entry above the lowest free
// slot writes the free slot and clears the dropped one in S_FREE. Close and drop with an
// in-range handle go through S_HWAIT. After reset the table is cleared one slot per cycle
// with req.ready low. Results are held in an output register until rsp.ready.
module tcp_connection_table_top #(
  parameter int ENTRIES = ctt_pkg::DEF_ENTRIES
) (
  input logic          clk,
  input logic          rst,
  ctt_stream_if.sink   req,
  ctt_stream_if.source rsp
);
  import ctt_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_FREE   = 7'b0010000,
    S_HWAIT  = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t        state;
  req_t          key;
  logic [IW-1:0] scan_addr;
  logic          look_vld;
  logic [IW-1:0] look_idx;
  logic [IW-1:0] free_slot;
  rsp_t          pend;
  rsp_t          out_q;
  logic          out_vld;

  logic          req_rdy;
  logic          req_acc;
  logic          busy;
  logic          bad_range;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        new_entry;
  entry_t        drop_entry;
  logic [IW-1:0] hnd_idx;

  match_flags_t  flags;
  logic [IW-1:0] fwd_idx;
  logic [IW-1:0] rev_idx;
  logic [IW-1:0] free_idx;
  logic          m_hit;
  logic          m_drop;
  logic          m_dir;
  logic [IW-1:0] m_idx;
  logic [IW-1:0] tgt_idx;
  logic          can_place;
  logic          is_open;
  logic          open_wr;
  logic          need_free;
  rsp_t          decide_rsp;
  rsp_t          hwait_rsp;

  assign req_rdy   = (state == S_IDLE) && !busy;
  assign req_acc   = req.valid && req_rdy;
  assign req.ready = req_rdy;
  assign rsp.valid = out_vld;
  assign rsp.data  = out_q;

  assign bad_range = int'(req.data.handle) >= ENTRIES;
  assign hnd_idx   = IW'(key.handle);
  assign rd_addr   = (state == S_IDLE) ? IW'(req.data.handle) : scan_addr;

  ctt_store #(.ENTRIES(ENTRIES)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (busy)
  );

  ctt_match #(.ENTRIES(ENTRIES)) u_match (
    .clk       (clk),
    .rst       (rst),
    .start     (req_acc),
    .look_vld  (look_vld),
    .look_idx  (look_idx),
    .look_data (rd_data),
    .key       (key),
    .flags     (flags),
    .fwd_idx   (fwd_idx),
    .rev_idx   (rev_idx),
    .free_idx  (free_idx)
  );

  assign m_hit     = flags.fwd_hit || flags.rev_hit;
  assign m_idx     = flags.fwd_hit ? fwd_idx : rev_idx;
  assign m_drop    = flags.fwd_hit ? flags.fwd_drop : flags.rev_drop;
  assign m_dir     = flags.fwd_hit || !m_hit;
  assign tgt_idx   = (m_hit && m_drop && !(flags.free_hit && free_idx < m_idx)) ?
                     m_idx : free_idx;
  assign can_place = (m_hit && m_drop) || flags.free_hit;
  assign is_open   = key.kind == KIND_OPEN;
  assign open_wr   = is_open && can_place && !(m_hit && !m_drop);
  assign need_free = is_open && m_hit && m_drop && (tgt_idx != m_idx);

  always_comb begin
    new_entry         = '0;
    new_entry.valid   = 1'b1;
    new_entry.src_ip  = key.src_ip;
    new_entry.dst_ip  = key.dst_ip;
    new_entry.ports   = {key.src_port, key.dst_port};
    drop_entry         = rd_data;
    drop_entry.dropped = 1'b1;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tgt_idx;
    wr_data = new_entry;
    unique case (state)
      S_DECIDE: begin
        wr_en = open_wr;
      end
      S_FREE: begin
        wr_en   = 1'b1;
        wr_addr = free_slot;
        wr_data = '0;
      end
      S_HWAIT: begin
        wr_en   = rd_data.valid;
        wr_addr = hnd_idx;
        wr_data = (key.kind == KIND_CLOSE) ? entry_t'('0) : drop_entry;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    decide_rsp         = '0;
    decide_rsp.status  = ST_OK;
    decide_rsp.forward = 1'b1;
    if (!is_open) begin
      if (!m_hit) begin
        decide_rsp.status = ST_NOT_FOUND;
      end else if (m_drop) begin
        decide_rsp.status       = ST_DROPPED;
        decide_rsp.forward      = m_dir;
        decide_rsp.dropped_flag = 1'b1;
      end else begin
        decide_rsp.slot    = SLOT_W'(m_idx);
        decide_rsp.forward = m_dir;
      end
    end else if (m_hit && !m_drop) begin
      decide_rsp.status  = ST_EXISTS;
      decide_rsp.forward = m_dir;
    end else if (!can_place) begin
      decide_rsp.status = ST_FULL;
    end else begin
      decide_rsp.slot         = SLOT_W'(tgt_idx);
      decide_rsp.dropped_flag = m_hit;
    end
  end

  always_comb begin
    hwait_rsp         = '0;
    hwait_rsp.forward = 1'b1;
    if (!rd_data.valid) begin
      hwait_rsp.status = ST_BAD_HANDLE;
    end else begin
      hwait_rsp.status       = ST_OK;
      hwait_rsp.slot         = key.handle;
      hwait_rsp.dropped_flag = (key.kind == KIND_CLOSE) ? rd_data.dropped : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    look_idx <= scan_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (state == S_RESP) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      look_vld <= 1'b0;
    end else begin
      look_vld <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            key <= req.data;
            if (req.data.kind == KIND_GET || req.data.kind == KIND_OPEN) begin
              scan_addr <= '0;
              state     <= S_SCAN;
            end else if (bad_range) begin
              pend  <= '{status: ST_BAD_HANDLE, slot: '0, forward: 1'b1,
                         dropped_flag: 1'b0};
              state <= S_RESP;
            end else begin
              state <= S_HWAIT;
            end
          end
        end
        S_SCAN: begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_addr == IW'(ENTRIES - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          pend      <= decide_rsp;
          free_slot <= m_idx;
          state     <= need_free ? S_FREE : S_RESP;
        end
        S_FREE: begin
          state <= S_RESP;
        end
        S_HWAIT: begin
          pend  <= hwait_rsp;
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_vld || rsp.ready) begin
            out_q <= pend;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/ctt_store.sv
module ctt_store #(
  parameter int ENTRIES = ctt_pkg::DEF_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  ctt_pkg::entry_t            wr_data,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output ctt_pkg::entry_t            rd_data,
  output logic                       busy
);
  import ctt_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  entry_t          mem [ENTRIES];
  logic [IW-1:0]   clr_addr;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IW'(ENTRIES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign mem_we    = busy || wr_en;
  assign mem_waddr = busy ? clr_addr : wr_addr;
  assign mem_wdata = busy ? entry_t'('0) : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/ctt_match.sv
module ctt_match #(
  parameter int ENTRIES = ctt_pkg::DEF_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       look_vld,
  input  logic [$clog2(ENTRIES)-1:0] look_idx,
  input  ctt_pkg::entry_t            look_data,
  input  ctt_pkg::req_t              key,
  output ctt_pkg::match_flags_t      flags,
  output logic [$clog2(ENTRIES)-1:0] fwd_idx,
  output logic [$clog2(ENTRIES)-1:0] rev_idx,
  output logic [$clog2(ENTRIES)-1:0] free_idx
);
  import ctt_pkg::*;

  logic fwd_eq;
  logic rev_eq;
  logic free_eq;

  assign fwd_eq  = look_data.valid && look_data.src_ip == key.src_ip &&
                   look_data.dst_ip == key.dst_ip &&
                   look_data.ports == {key.src_port, key.dst_port};
  assign rev_eq  = look_data.valid && look_data.src_ip == key.dst_ip &&
                   look_data.dst_ip == key.src_ip &&
                   look_data.ports == {key.dst_port, key.src_port};
  assign free_eq = !look_data.valid;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
    end else if (look_vld) begin
      if (fwd_eq && !flags.fwd_hit) begin
        flags.fwd_hit  <= 1'b1;
        flags.fwd_drop <= look_data.dropped;
      end
      if (rev_eq && !flags.rev_hit) begin
        flags.rev_hit  <= 1'b1;
        flags.rev_drop <= look_data.dropped;
      end
      if (free_eq && !flags.free_hit) begin
        flags.free_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (look_vld && !start) begin
      if (fwd_eq && !flags.fwd_hit) begin
        fwd_idx <= look_idx;
      end
      if (rev_eq && !flags.rev_hit) begin
        rev_idx <= look_idx;
      end
      if (free_eq && !flags.free_hit) begin
        free_idx <= look_idx;
      end
    end
  end

endmodule
